>>> design/assert_macros.svh
// Assertion macros used by the top level of the I2C register access master RTL.
// Simulation builds get concurrent assertions; SYNTH builds get empty bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_IMPLY(lbl, clk_s, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk_s) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("assertion failed");
`define ASSERT_NEVER(lbl, clk_s, rst_n, expr) \
	lbl: assert property (@(posedge clk_s) disable iff (!(rst_n)) !(expr)) \
		else $error("assertion failed");
`else
`define ASSERT_IMPLY(lbl, clk_s, rst_n, ante, cons)
`define ASSERT_NEVER(lbl, clk_s, rst_n, expr)
`endif
`endif

>>> design/i2cra_pkg.sv
// Shared types and codes for the I2C register access master.
// No dependencies; imported by the front, sequencer and top level.
package i2cra_pkg;
	localparam int QUEUE_DEPTH = 2;
	localparam int BITS_PER_BYTE = 8;
	localparam logic [7:0] ADDR_RESET = 8'd208;
	localparam logic [9:0] DELAY_RESET = 10'd1;

	localparam logic [1:0] KIND_TICK = 2'd0;
	localparam logic [1:0] KIND_WRITE = 2'd1;
	localparam logic [1:0] KIND_READ = 2'd2;
	localparam logic [1:0] KIND_WORD = 2'd3;

	localparam logic [3:0] PH_IDLE = 4'd0;
	localparam logic [3:0] PH_START_A = 4'd1;
	localparam logic [3:0] PH_START_B = 4'd2;
	localparam logic [3:0] PH_TX_LOW = 4'd3;
	localparam logic [3:0] PH_TX_HIGH = 4'd4;
	localparam logic [3:0] PH_ACK_LOW = 4'd5;
	localparam logic [3:0] PH_ACK_HIGH = 4'd6;
	localparam logic [3:0] PH_RX_LOW = 4'd7;
	localparam logic [3:0] PH_RX_HIGH = 4'd8;
	localparam logic [3:0] PH_NACK_LOW = 4'd9;
	localparam logic [3:0] PH_NACK_HIGH = 4'd10;
	localparam logic [3:0] PH_STOP_A = 4'd11;
	localparam logic [3:0] PH_STOP_B = 4'd12;
	localparam logic [3:0] PH_STOP_C = 4'd13;
	localparam logic [3:0] PH_RSTART = 4'd14;

	localparam logic [1:0] ST_ADDR_W = 2'd0;
	localparam logic [1:0] ST_REG = 2'd1;
	localparam logic [1:0] ST_DATA = 2'd2;
	localparam logic [1:0] ST_ADDR_R = 2'd3;

	localparam logic [1:0] CFG_DEV_ADDR = 2'd0;
	localparam logic [1:0] CFG_DELAY = 2'd1;

	typedef struct packed {
		logic       is_cmd;
		logic [1:0] kind;
		logic [7:0] target_reg;
		logic [7:0] write_data;
		logic       sda_in;
	} tick_t;

	typedef struct packed {
		logic        nack_seen;
		logic [15:0] word_data;
		logic [7:0]  byte_data;
		logic        done_res;
		logic        busy_res;
		logic        sda_level;
		logic        scl_level;
	} result_t;

	typedef struct packed {
		logic [7:0] dev_addr;
		logic [9:0] delay;
	} cfg_t;
endpackage

>>> design/i2c_register_access_master_unit.sv
// With an empty queue a tick's result passes through the queue slot and then the sequencer's output register.
// Throughput: one tick per cycle; the sequencer takes one queued tick each cycle
// that its output register is free or being taken.
// Bus timing is counted in ticks, cfg.delay ticks per bus phase (a delay of zero counts as one).
// Reset: asynchronous, active low; sequencer idle, queue empty, device address 208
// and one tick per delay phase.
`include "assert_macros.svh"
module i2c_register_access_master_unit #(
	parameter int QDEPTH = i2cra_pkg::QUEUE_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,    // target_reg[7:0], write_data[15:8], sda_in[16], zero
	input  logic [1:0]  s_tuser,    // kind[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	// scl_level[0], sda_level[1], busy_res[2], done_res[3], byte_data[11:4],
	// word_data[27:12], nack_seen[28], zero
	output logic [31:0] m_tdata,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [9:0]  cfg_data
);
	import i2cra_pkg::*;

	cfg_t    cfg_q;
	tick_t   q_item;
	logic    q_valid;
	logic    q_pop;
	result_t res;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.dev_addr <= ADDR_RESET;
			cfg_q.delay <= DELAY_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_DEV_ADDR: cfg_q.dev_addr <= cfg_data[7:0];
				CFG_DELAY: cfg_q.delay <= cfg_data;
				default: ;
			endcase
		end
	end

	i2cra_front #(
		.DEPTH(QDEPTH)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(s_tvalid),
		.in_ready(s_tready),
		.in_kind(s_tuser),
		.in_data(s_tdata[16:0]),
		.q_valid(q_valid),
		.q_pop(q_pop),
		.q_item(q_item)
	);

	i2cra_seq u_seq (
		.clk(clk),
		.arst_n(arst_n),
		.q_valid(q_valid),
		.q_pop(q_pop),
		.q_item(q_item),
		.cfg(cfg_q),
		.res_valid(m_tvalid),
		.res_ready(m_tready),
		.res(res)
	);

	assign m_tdata = {3'd0, res};

	`ASSERT_IMPLY(a_done_idle, clk, arst_n, m_tvalid && res.done_res,
		!res.busy_res && res.scl_level && res.sda_level)
	`ASSERT_NEVER(a_byte_only_done, clk, arst_n, m_tvalid && !res.done_res && res.byte_data != 8'd0)
	`ASSERT_NEVER(a_word_only_done, clk, arst_n, m_tvalid && !res.done_res && res.word_data != 16'd0)
	`ASSERT_IMPLY(a_pop_moves, clk, arst_n, q_pop, ##1 m_tvalid)
endmodule

>>> design/i2cra_front.sv
// Input side of the I2C register access master: takes ticks, marks commands
// and holds them in a short queue for the sequencer. Depends on i2cra_pkg.
module i2cra_front #(
	parameter int DEPTH = i2cra_pkg::QUEUE_DEPTH
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [1:0]        in_kind,
	input  logic [16:0]       in_data,
	output logic              q_valid,
	input  logic              q_pop,
	output i2cra_pkg::tick_t  q_item
);
	import i2cra_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	tick_t          slot_q [DEPTH];
	logic [AW-1:0]  wr_ptr_q;
	logic [AW-1:0]  rd_ptr_q;
	logic [CW-1:0]  count_q;
	tick_t          item;
	logic           push;
	logic           pop;

	always_comb begin
		item.kind = in_kind;
		item.is_cmd = in_kind != KIND_TICK;
		item.target_reg = in_data[7:0];
		item.write_data = in_data[15:8];
		item.sda_in = in_data[16];
	end

	assign in_ready = count_q != CW'(DEPTH);
	assign q_valid = count_q != '0;
	assign push = in_valid && in_ready;
	assign pop = q_pop && q_valid;
	assign q_item = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end
endmodule

>>> design/i2cra_seq.sv
// Bus sequencer of the I2C register access master: one tick per step,
// result held in an output register. Depends on i2cra_pkg.
module i2cra_seq (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                q_valid,
	output logic                q_pop,
	input  i2cra_pkg::tick_t    q_item,
	input  i2cra_pkg::cfg_t     cfg,
	output logic                res_valid,
	input  logic                res_ready,
	output i2cra_pkg::result_t  res
);
	import i2cra_pkg::*;

	logic [3:0] phase_q;
	logic [3:0] bit_count_q;
	logic [9:0] delay_count_q;
	logic [7:0] shift_q;
	logic [1:0] kind_q;
	logic [7:0] lreg_q;
	logic [7:0] ldata_q;
	logic [7:0] high_q;
	logic       nack_q;
	logic [1:0] stage_q;
	logic       second_q;
	logic       valid_q;
	result_t    res_q;

	logic [3:0] ph0, ph_n;
	logic [3:0] bc0, bc_n, bc_inc;
	logic [9:0] dc0, dc_n, dc_inc, limit;
	logic [7:0] sh_n;
	logic [1:0] kd0;
	logic [7:0] lreg0, lreg_n, ldata0, high0, high_n;
	logic       nack0, nack_n, second0, second_n, done;
	logic [1:0] st0, st_n, lv;
	logic       start, advance;
	result_t    r;

	assign advance = q_valid && (!valid_q || res_ready);
	assign q_pop = advance;

	always_comb begin
		start = (phase_q == PH_IDLE) && q_item.is_cmd;
		ph0 = start ? PH_START_A : phase_q;
		kd0 = start ? q_item.kind : kind_q;
		lreg0 = start ? q_item.target_reg : lreg_q;
		ldata0 = start ? q_item.write_data : ldata_q;
		nack0 = start ? 1'b0 : nack_q;
		second0 = start ? 1'b0 : second_q;
		high0 = start ? 8'd0 : high_q;
		st0 = start ? ST_ADDR_W : stage_q;
		bc0 = start ? 4'd0 : bit_count_q;
		dc0 = start ? 10'd0 : delay_count_q;
		limit = (cfg.delay == 10'd0) ? 10'd1 : cfg.delay;

		unique case (ph0)
			PH_START_B: lv = 2'b10;
			PH_TX_LOW: lv = {1'b0, shift_q[7]};
			PH_TX_HIGH: lv = {1'b1, shift_q[7]};
			PH_ACK_LOW, PH_RX_LOW, PH_NACK_LOW, PH_RSTART: lv = 2'b01;
			PH_STOP_A: lv = 2'b00;
			PH_STOP_B: lv = 2'b10;
			default: lv = 2'b11;
		endcase

		ph_n = ph0;
		bc_n = bc0;
		dc_n = dc0;
		sh_n = shift_q;
		lreg_n = lreg0;
		high_n = high0;
		nack_n = nack0;
		second_n = second0;
		st_n = st0;
		done = 1'b0;
		dc_inc = dc0 + 10'd1;
		bc_inc = bc0 + 4'd1;

		if (ph0 != PH_IDLE) begin
			dc_n = dc_inc;
			if (dc_inc >= limit) begin
				dc_n = '0;
				unique case (ph0)
					PH_START_A: ph_n = PH_START_B;
					PH_START_B: begin
						sh_n = (st0 == ST_ADDR_R) ? cfg.dev_addr + 8'd1 : cfg.dev_addr;
						bc_n = '0;
						ph_n = PH_TX_LOW;
					end
					PH_TX_LOW: ph_n = PH_TX_HIGH;
					PH_TX_HIGH: begin
						sh_n = {shift_q[6:0], 1'b0};
						bc_n = bc_inc;
						ph_n = (bc_inc >= 4'(BITS_PER_BYTE)) ? PH_ACK_LOW : PH_TX_LOW;
					end
					PH_ACK_LOW: ph_n = PH_ACK_HIGH;
					PH_ACK_HIGH: begin
						if (q_item.sda_in) begin
							nack_n = 1'b1;
						end
						bc_n = '0;
						unique case (st0)
							ST_ADDR_W: begin
								sh_n = lreg0;
								st_n = ST_REG;
								ph_n = PH_TX_LOW;
							end
							ST_REG: begin
								if (kd0 == KIND_WRITE) begin
									sh_n = ldata0;
									st_n = ST_DATA;
									ph_n = PH_TX_LOW;
								end else begin
									st_n = ST_ADDR_R;
									ph_n = PH_RSTART;
								end
							end
							ST_DATA: ph_n = PH_STOP_A;
							default: begin
								sh_n = '0;
								ph_n = PH_RX_LOW;
							end
						endcase
					end
					PH_RSTART: ph_n = PH_START_A;
					PH_RX_LOW: ph_n = PH_RX_HIGH;
					PH_RX_HIGH: begin
						sh_n = {shift_q[6:0], q_item.sda_in};
						bc_n = bc_inc;
						ph_n = (bc_inc >= 4'(BITS_PER_BYTE)) ? PH_NACK_LOW : PH_RX_LOW;
					end
					PH_NACK_LOW: ph_n = PH_NACK_HIGH;
					PH_NACK_HIGH: ph_n = PH_STOP_A;
					PH_STOP_A: ph_n = PH_STOP_B;
					PH_STOP_B: ph_n = PH_STOP_C;
					default: begin
						if (kd0 == KIND_WORD && !second0) begin
							high_n = shift_q;
							second_n = 1'b1;
							lreg_n = lreg0 + 8'd1;
							st_n = ST_ADDR_W;
							ph_n = PH_START_A;
						end else begin
							done = 1'b1;
							ph_n = PH_IDLE;
						end
					end
				endcase
			end
		end

		r.scl_level = lv[1];
		r.sda_level = lv[0];
		r.busy_res = ph_n != PH_IDLE;
		r.done_res = done;
		r.byte_data = (done && kd0 != KIND_WRITE) ? shift_q : 8'd0;
		r.word_data = (done && kd0 == KIND_WORD) ? {high0, shift_q} : 16'd0;
		r.nack_seen = nack_n;
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= r;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			bit_count_q <= '0;
			delay_count_q <= '0;
			shift_q <= '0;
			kind_q <= KIND_TICK;
			lreg_q <= '0;
			ldata_q <= '0;
			high_q <= '0;
			nack_q <= 1'b0;
			stage_q <= ST_ADDR_W;
			second_q <= 1'b0;
			valid_q <= 1'b0;
		end else begin
			if (advance) begin
				phase_q <= ph_n;
				bit_count_q <= bc_n;
				delay_count_q <= dc_n;
				shift_q <= sh_n;
				kind_q <= kd0;
				lreg_q <= lreg_n;
				ldata_q <= ldata0;
				high_q <= high_n;
				nack_q <= nack_n;
				stage_q <= st_n;
				second_q <= second_n;
				valid_q <= 1'b1;
			end else if (res_ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	assign res_valid = valid_q;
	assign res = res_q;
endmodule
